// File: hdl/sesq_pkg.sv
// Shared types and constants of the sound-effect sweep sequencer.
package sesq_pkg;

   localparam int CHANNELS = 3;
   localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [6:0] PERIOD_MASK = 7'h7f;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef struct packed {
      logic [6:0] tone;
      logic [7:0] freq;
      logic [7:0] sweep;
      logic [7:0] period;
      logic [7:0] bstep;
      logic [7:0] repeats;
      logic [3:0] vol;
      logic [7:0] vstep;
   } desc_type;

   typedef struct packed {
      logic        active;
      logic        load_pending;
      logic        reversed;
      logic [7:0]  root_freq;
      logic [7:0]  cur_freq;
      logic [7:0]  sweep_inc;
      logic [7:0]  period_cnt;
      logic [7:0]  repeats_left;
      logic [7:0]  cur_vol;
      logic [14:0] held_freq;
      logic [2:0]  held_wave;
   } voice_type;

endpackage

// File: hdl/sound_effect_sweep_sequencer_unit.sv
// Top level of the three-voice sound-effect sweep sequencer.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  mode, channel, effect descriptor
//   rsp_      out         rsp_valid/rsp_stall  channel, frequency, wave, volume, playing
//
// One word is accepted per cycle unless stalled; each gives exactly one result word.
// A word sits in the input register, where the voice state is read, updated
// and written back, and then moves to the result register, from which it is presented.
// Reset clears all voice state but the stored descriptors.
// A stalled result holds the input register, which then stalls the request side.
module sound_effect_sweep_sequencer_unit
   import sesq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_channel,
   input  logic [6:0]  req_tone_select,
   input  logic [7:0]  req_start_freq,
   input  logic [7:0]  req_sweep_step,
   input  logic [7:0]  req_period_control,
   input  logic [7:0]  req_base_step,
   input  logic [7:0]  req_repeat_count,
   input  logic [3:0]  req_start_volume,
   input  logic [7:0]  req_volume_step,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_channel,
   output logic [14:0] rsp_frequency,
   output logic [2:0]  rsp_wave,
   output logic [7:0]  rsp_volume,
   output logic        rsp_playing
);

   logic            s1_valid_ff, s1_valid_in;
   mode_type        s1_mode_ff;
   logic [1:0]      s1_channel_ff;
   desc_type        s1_desc_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_out_channel_ff;
   logic [14:0]     rsp_frequency_ff, rsp_frequency_in;
   logic [2:0]      rsp_wave_ff, rsp_wave_in;
   logic [7:0]      rsp_volume_ff, rsp_volume_in;
   logic            rsp_playing_ff, rsp_playing_in;

   voice_type       voice_ff [CHANNELS];
   desc_type        desc_ff [CHANNELS];

   logic            out_free, s1_fire, req_fire, s1_in_range;
   logic [CHAN_IDX_W-1:0] s1_idx;
   voice_type       v_cur, v_next, v_tick;
   desc_type        d_cur;
   logic [7:0]      tick_volume;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire     = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !out_free;
   assign req_fire    = req_valid && !req_stall;
   assign s1_valid_in = req_fire || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   assign s1_in_range = (32'(s1_channel_ff) < CHANNELS);
   assign s1_idx      = s1_in_range ? CHAN_IDX_W'(s1_channel_ff) : '0;
   assign v_cur       = voice_ff[s1_idx];
   assign d_cur       = desc_ff[s1_idx];

   sesq_voice_tick u_tick (
      .voice_in   (v_cur),
      .desc_in    (d_cur),
      .voice_out  (v_tick),
      .volume_out (tick_volume)
   );

   always_comb begin
      v_next           = v_cur;
      rsp_frequency_in = 15'd0;
      rsp_wave_in      = 3'd0;
      rsp_volume_in    = 8'd0;
      case (s1_mode_ff)
         MODE_TICK: begin
            v_next           = v_tick;
            rsp_frequency_in = v_tick.held_freq;
            rsp_wave_in      = v_tick.held_wave;
            rsp_volume_in    = tick_volume;
         end
         MODE_START: begin
            v_next.active       = 1'b1;
            v_next.load_pending = 1'b1;
         end
         MODE_STOP: begin
            v_next.active = 1'b0;
         end
         MODE_QUERY: begin
            v_next = v_cur;
         end
         default: begin
            v_next = v_cur;
         end
      endcase
      rsp_playing_in = v_next.active;
      if (!s1_in_range) begin
         rsp_frequency_in = 15'd0;
         rsp_wave_in      = 3'd0;
         rsp_volume_in    = 8'd0;
         rsp_playing_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            voice_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire && s1_in_range) begin
            voice_ff[s1_idx] <= v_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff         <= mode_type'(req_mode);
         s1_channel_ff      <= req_channel;
         s1_desc_ff.tone    <= req_tone_select;
         s1_desc_ff.freq    <= req_start_freq;
         s1_desc_ff.sweep   <= req_sweep_step;
         s1_desc_ff.period  <= req_period_control;
         s1_desc_ff.bstep   <= req_base_step;
         s1_desc_ff.repeats <= req_repeat_count;
         s1_desc_ff.vol     <= req_start_volume;
         s1_desc_ff.vstep   <= req_volume_step;
      end
      if (s1_fire && s1_in_range && (s1_mode_ff == MODE_START)) begin
         desc_ff[s1_idx] <= s1_desc_ff;
      end
      if (s1_fire) begin
         rsp_out_channel_ff <= s1_channel_ff;
         rsp_frequency_ff   <= rsp_frequency_in;
         rsp_wave_ff        <= rsp_wave_in;
         rsp_volume_ff      <= rsp_volume_in;
         rsp_playing_ff     <= rsp_playing_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_out_channel_ff;
   assign rsp_frequency   = rsp_frequency_ff;
   assign rsp_wave        = rsp_wave_ff;
   assign rsp_volume      = rsp_volume_ff;
   assign rsp_playing     = rsp_playing_ff;

   // The request side is only held back by a word waiting in the input register.
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with an empty input register");

   // A silent voice never reports a non-zero volume.
   a_idle_is_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_playing_ff) |-> (rsp_volume_ff == 8'd0))
      else $error("volume reported for a voice that is not playing");

   // A word for a voice that does not exist yields an empty result.
   a_bad_channel_empty: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_in_range) |=>
         (!rsp_playing_ff && (rsp_frequency_ff == 15'd0) && (rsp_volume_ff == 8'd0)))
      else $error("result for a missing voice is not empty");

   // A start always leaves the voice playing.
   a_start_plays: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_in_range && (s1_mode_ff == MODE_START)) |=> rsp_playing_ff)
      else $error("started voice does not report playing");

endmodule

// File: hdl/sesq_voice_tick.sv
// Combinational tick update of one voice: load, period, repeat and sweep steps.
module sesq_voice_tick
   import sesq_pkg::*;
(
   input  voice_type  voice_in,
   input  desc_type   desc_in,
   output voice_type  voice_out,
   output logic [7:0] volume_out
);

   voice_type   s;
   logic [7:0]  pc;
   logic [7:0]  rl;
   logic [14:0] wide;
   logic [2:0]  shift;

   always_comb begin
      s          = voice_in;
      volume_out = 8'd0;
      pc         = 8'd0;
      rl         = 8'd0;
      wide       = 15'd0;
      shift      = desc_in.tone[6:4];
      if (voice_in.active) begin
         if (s.load_pending) begin
            s.load_pending = 1'b0;
            s.reversed     = 1'b0;
            s.root_freq    = desc_in.freq;
            s.cur_freq     = desc_in.freq;
            s.sweep_inc    = desc_in.sweep;
            s.period_cnt   = {1'b0, desc_in.period[6:0] & PERIOD_MASK};
            s.repeats_left = desc_in.repeats;
            s.cur_vol      = {4'd0, desc_in.vol};
         end
         pc           = s.period_cnt - 8'd1;
         s.period_cnt = pc;
         rl           = s.repeats_left - 8'd1;
         if ((pc == 8'd0) && (s.repeats_left != 8'd0) && (rl == 8'd0)) begin
            // The last repeat has finished: the voice falls silent.
            s.repeats_left = 8'd0;
            s.active       = 1'b0;
         end else begin
            if (pc == 8'd0) begin
               if (s.repeats_left != 8'd0) begin
                  s.repeats_left = rl;
               end
               s.period_cnt = {1'b0, desc_in.period[6:0] & PERIOD_MASK};
               if (desc_in.period[7]) begin
                  s.sweep_inc = 8'(~s.sweep_inc + 8'd1);
                  s.reversed  = ~s.reversed;
               end
               if (!s.reversed) begin
                  s.root_freq = s.root_freq + desc_in.bstep;
                  s.cur_freq  = s.root_freq;
                  s.cur_vol   = s.cur_vol + desc_in.vstep;
               end
            end
            s.cur_freq  = s.cur_freq + s.sweep_inc;
            wide        = {7'd0, s.cur_freq};
            s.held_freq = wide << shift;
            s.held_wave = desc_in.tone[2:0];
            volume_out  = s.cur_vol;
         end
      end
      voice_out = s;
   end

endmodule

// File: test/sesq_effect_checker.sv
`timescale 1ns / 1ps
// Checker for the sweep sequencer: watches all three channels, predicts each result word and compares.
module sesq_effect_checker
   import sesq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_channel,
   input  logic [6:0]  req_tone_select,
   input  logic [7:0]  req_start_freq,
   input  logic [7:0]  req_sweep_step,
   input  logic [7:0]  req_period_control,
   input  logic [7:0]  req_base_step,
   input  logic [7:0]  req_repeat_count,
   input  logic [3:0]  req_start_volume,
   input  logic [7:0]  req_volume_step,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_out_channel,
   input  logic [14:0] rsp_frequency,
   input  logic [2:0]  rsp_wave,
   input  logic [7:0]  rsp_volume,
   input  logic        rsp_playing,
   output int unsigned mismatch_count,
   output int unsigned awaited_count
);

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic [1:0]  chan;
      logic [14:0] freq;
      logic [2:0]  wave;
      logic [7:0]  vol;
      logic        playing;
   } report_type;

   voice_type   voices [CHANNELS];
   desc_type    effects [CHANNELS];
   report_type  expected_reports [$];

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t: mismatch: %s", $realtime, msg);
      end
      mismatch_count = mismatch_count + 1;
   endtask

   always @(posedge clock) begin
      voice_type   v;
      desc_type    d;
      report_type  r;
      logic        ended;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            voices[i]  = '0;
            effects[i] = '0;
         end
         expected_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               report_mismatch($sformatf("result word for channel %0d with none expected",
                                         rsp_out_channel));
            end else begin
               r = expected_reports.pop_front();
               if (rsp_out_channel !== r.chan)
                  report_mismatch($sformatf("channel got %0d expected %0d",
                                            rsp_out_channel, r.chan));
               if (rsp_frequency !== r.freq)
                  report_mismatch($sformatf("channel %0d frequency got %0h expected %0h",
                                            r.chan, rsp_frequency, r.freq));
               if (rsp_wave !== r.wave)
                  report_mismatch($sformatf("channel %0d wave got %0d expected %0d",
                                            r.chan, rsp_wave, r.wave));
               if (rsp_volume !== r.vol)
                  report_mismatch($sformatf("channel %0d volume got %0h expected %0h",
                                            r.chan, rsp_volume, r.vol));
               if (rsp_playing !== r.playing)
                  report_mismatch($sformatf("channel %0d playing got %0b expected %0b",
                                            r.chan, rsp_playing, r.playing));
            end
         end
         if (req_valid && !req_stall) begin
            r      = '0;
            r.chan = req_channel;
            if (req_channel < CHANNELS) begin
               case (mode_type'(req_mode))
                  MODE_TICK: begin
                     v     = voices[req_channel];
                     d     = effects[req_channel];
                     ended = 1'b0;
                     if (v.active) begin
                        if (v.load_pending) begin
                           v.load_pending = 1'b0;
                           v.reversed     = 1'b0;
                           v.root_freq    = d.freq;
                           v.cur_freq     = d.freq;
                           v.sweep_inc    = d.sweep;
                           v.period_cnt   = {1'b0, d.period[6:0] & PERIOD_MASK};
                           v.repeats_left = d.repeats;
                           v.cur_vol      = {4'd0, d.vol};
                        end
                        v.period_cnt = v.period_cnt - 8'd1;
                        if (v.period_cnt == 8'd0 && v.repeats_left != 8'd0) begin
                           v.repeats_left = v.repeats_left - 8'd1;
                           if (v.repeats_left == 8'd0) begin
                              v.active = 1'b0;
                              ended    = 1'b1;
                           end
                        end
                        if (!ended) begin
                           if (v.period_cnt == 8'd0) begin
                              v.period_cnt = {1'b0, d.period[6:0] & PERIOD_MASK};
                              if (d.period[7]) begin
                                 v.sweep_inc = 8'd0 - v.sweep_inc;
                                 v.reversed  = ~v.reversed;
                              end
                              if (!v.reversed) begin
                                 v.root_freq = v.root_freq + d.bstep;
                                 v.cur_freq  = v.root_freq;
                                 v.cur_vol   = v.cur_vol + d.vstep;
                              end
                           end
                           v.cur_freq  = v.cur_freq + v.sweep_inc;
                           v.held_freq = {7'd0, v.cur_freq} << d.tone[6:4];
                           v.held_wave = d.tone[2:0];
                           r.vol       = v.cur_vol;
                        end
                     end
                     r.freq = v.held_freq;
                     r.wave = v.held_wave;
                     voices[req_channel] = v;
                  end
                  MODE_START: begin
                     effects[req_channel] = {req_tone_select, req_start_freq, req_sweep_step,
                                             req_period_control, req_base_step,
                                             req_repeat_count, req_start_volume,
                                             req_volume_step};
                     voices[req_channel].active       = 1'b1;
                     voices[req_channel].load_pending = 1'b1;
                  end
                  MODE_STOP: begin
                     voices[req_channel].active = 1'b0;
                  end
                  default: begin
                  end
               endcase
               r.playing = voices[req_channel].active;
            end
            expected_reports.push_back(r);
         end
      end
      awaited_count = expected_reports.size();
   end

endmodule

// File: test/tb_sound_effect_sweep_sequencer_unit.sv
`timescale 1ns / 1ps
// Testbench top for the sweep sequencer: drives directed and random words and gives the verdict.
module tb_sound_effect_sweep_sequencer_unit
   import sesq_pkg::*;
();

   localparam int RANDOM_WORDS   = 1500;
   localparam int IDLE_PCT       = 27;
   localparam int WATCHDOG_LIMIT = 1000;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode           = '0;
   logic [1:0]  req_channel        = '0;
   logic [6:0]  req_tone_select    = '0;
   logic [7:0]  req_start_freq     = '0;
   logic [7:0]  req_sweep_step     = '0;
   logic [7:0]  req_period_control = '0;
   logic [7:0]  req_base_step      = '0;
   logic [7:0]  req_repeat_count   = '0;
   logic [3:0]  req_start_volume   = '0;
   logic [7:0]  req_volume_step    = '0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [1:0]  rsp_out_channel;
   logic [14:0] rsp_frequency;
   logic [2:0]  rsp_wave;
   logic [7:0]  rsp_volume;
   logic        rsp_playing;

   bit          quiet = 1'b0;
   int unsigned idle_cycles = 0;
   int unsigned mismatch_count;
   int unsigned awaited_count;

   sound_effect_sweep_sequencer_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_channel        (req_channel),
      .req_tone_select    (req_tone_select),
      .req_start_freq     (req_start_freq),
      .req_sweep_step     (req_sweep_step),
      .req_period_control (req_period_control),
      .req_base_step      (req_base_step),
      .req_repeat_count   (req_repeat_count),
      .req_start_volume   (req_start_volume),
      .req_volume_step    (req_volume_step),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_frequency      (rsp_frequency),
      .rsp_wave           (rsp_wave),
      .rsp_volume         (rsp_volume),
      .rsp_playing        (rsp_playing)
   );

   sesq_effect_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_channel        (req_channel),
      .req_tone_select    (req_tone_select),
      .req_start_freq     (req_start_freq),
      .req_sweep_step     (req_sweep_step),
      .req_period_control (req_period_control),
      .req_base_step      (req_base_step),
      .req_repeat_count   (req_repeat_count),
      .req_start_volume   (req_start_volume),
      .req_volume_step    (req_volume_step),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_frequency      (rsp_frequency),
      .rsp_wave           (rsp_wave),
      .rsp_volume         (rsp_volume),
      .rsp_playing        (rsp_playing),
      .mismatch_count     (mismatch_count),
      .awaited_count      (awaited_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic desc_type make_effect(input logic [6:0] tone, input logic [7:0] freq,
                                            input logic [7:0] sweep, input logic [7:0] period,
                                            input logic [7:0] bstep, input logic [7:0] repeats,
                                            input logic [3:0] vol, input logic [7:0] vstep);
      desc_type d;
      d.tone    = tone;
      d.freq    = freq;
      d.sweep   = sweep;
      d.period  = period;
      d.bstep   = bstep;
      d.repeats = repeats;
      d.vol     = vol;
      d.vstep   = vstep;
      return d;
   endfunction

   // Mostly short periods and few repeats, so that effects end often.
   function automatic desc_type random_effect();
      desc_type    d;
      int unsigned pick;
      d.tone   = 7'($urandom_range(0, 127));
      d.freq   = 8'($urandom_range(0, 255));
      d.sweep  = 8'($urandom_range(0, 255));
      d.period = 8'($urandom_range(0, 255));
      d.bstep  = 8'($urandom_range(0, 255));
      d.vol    = 4'($urandom_range(0, 15));
      d.vstep  = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         d.period[6:0] = 7'($urandom_range(1, 4));
      end else if (pick == 9) begin
         d.period[6:0] = 7'd0;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         d.repeats = 8'd0;
      end else if (pick < 9) begin
         d.repeats = 8'($urandom_range(1, 5));
      end else begin
         d.repeats = 8'($urandom_range(0, 255));
      end
      return d;
   endfunction

   task automatic send_word(input mode_type m, input logic [1:0] ch, input desc_type d);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= m;
      req_channel        <= ch;
      req_tone_select    <= d.tone;
      req_start_freq     <= d.freq;
      req_sweep_step     <= d.sweep;
      req_period_control <= d.period;
      req_base_step      <= d.bstep;
      req_repeat_count   <= d.repeats;
      req_start_volume   <= d.vol;
      req_volume_step    <= d.vstep;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int unsigned roll;
      mode_type    m;
      logic [1:0]  ch;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(MODE_QUERY, 2'd0, random_effect());
      send_word(MODE_TICK, 2'd1, random_effect());
      send_word(MODE_TICK, 2'd3, random_effect());
      send_word(MODE_START, 2'd3, random_effect());
      send_word(MODE_STOP, 2'd3, random_effect());
      send_word(MODE_QUERY, 2'd3, random_effect());
      send_word(MODE_START, 2'd0, make_effect(7'h7f, 8'hff, 8'h80, 8'h81, 8'hff, 8'd3, 4'hf,
                                              8'hff));
      repeat (4) send_word(MODE_TICK, 2'd0, random_effect());
      send_word(MODE_START, 2'd1, make_effect(7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 4'h0,
                                              8'h00));
      repeat (2) send_word(MODE_TICK, 2'd1, random_effect());
      send_word(MODE_STOP, 2'd1, random_effect());
      send_word(MODE_TICK, 2'd1, random_effect());
      send_word(MODE_START, 2'd2, make_effect(7'h35, 8'h10, 8'h7f, 8'h02, 8'h01, 8'd0, 4'h8,
                                              8'h01));
      repeat (2) send_word(MODE_TICK, 2'd2, random_effect());
      send_word(MODE_START, 2'd2, make_effect(7'h4a, 8'hf0, 8'h01, 8'h83, 8'h20, 8'd2, 4'h1,
                                              8'hf0));
      send_word(MODE_TICK, 2'd2, random_effect());
      send_word(MODE_QUERY, 2'd2, random_effect());
      repeat (3) send_word(MODE_TICK, 2'd2, random_effect());

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet = (n >= 600 && n < 900);
         ch    = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
         roll  = $urandom_range(0, 99);
         if (roll < 72) begin
            m = MODE_TICK;
         end else if (roll < 84) begin
            m = MODE_START;
         end else if (roll < 90) begin
            m = MODE_STOP;
         end else begin
            m = MODE_QUERY;
         end
         send_word(m, ch, random_effect());
      end
      quiet = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/sesq_pkg.sv
hdl/sesq_voice_tick.sv
hdl/sound_effect_sweep_sequencer_unit.sv
test/sesq_effect_checker.sv
test/tb_sound_effect_sweep_sequencer_unit.sv
